>>> rtl/canopen_drive_state_sequencer_core_defines.svh
// Assertion macros shared by the drive state sequencer modules.
`ifndef CANOPEN_DRIVE_STATE_SEQUENCER_CORE_DEFINES_SVH
`define CANOPEN_DRIVE_STATE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CDSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked on every clock edge outside reset.
`define CDSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/cdss_pkg.sv
// Shared types, codes and helper functions of the drive state sequencer.
package cdss_pkg;

  typedef enum logic [1:0] {
    OP_SENT  = 2'd0,
    OP_RECV  = 2'd1,
    OP_QUERY = 2'd2,
    OP_FORCE = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NODE_ID_A = 2'd0;
  localparam logic [1:0] CFG_NODE_ID_B = 2'd1;
  localparam logic [1:0] CFG_NODE_ID_C = 2'd2;

  localparam int unsigned SLOT_COUNT = 3;
  localparam logic [6:0] NODE_ID_A_RESET = 7'd2;
  localparam logic [6:0] NODE_ID_B_RESET = 7'd4;
  localparam logic [6:0] NODE_ID_C_RESET = 7'd8;

  localparam logic [10:0] SENT_BASE = 11'h600;
  localparam logic [10:0] RECV_BASE = 11'h580;

  // Object kinds.
  localparam logic [2:0] OBJ_CONTROLWORD = 3'd0;
  localparam logic [2:0] OBJ_STATUSWORD  = 3'd1;
  localparam logic [2:0] OBJ_TARGET_VEL  = 3'd2;
  localparam logic [2:0] OBJ_VELOCITY    = 3'd3;
  localparam logic [2:0] OBJ_CURRENT     = 3'd4;
  localparam logic [2:0] OBJ_POSITION    = 3'd5;

  // Drive state codes.
  localparam logic [4:0] ST_BEFORE_START    = 5'd0;
  localparam logic [4:0] ST_GET_STATUS      = 5'd1;
  localparam logic [4:0] ST_STATUS_SENT     = 5'd2;
  localparam logic [4:0] ST_SW_ON_DISABLED  = 5'd3;
  localparam logic [4:0] ST_SHUTDOWN_SENT   = 5'd4;
  localparam logic [4:0] ST_READY_SW_ON     = 5'd5;
  localparam logic [4:0] ST_SWITCH_ON_SENT  = 5'd6;
  localparam logic [4:0] ST_SWITCHED_ON     = 5'd7;
  localparam logic [4:0] ST_ENABLE_SENT     = 5'd8;
  localparam logic [4:0] ST_OP_ENABLED      = 5'd9;
  localparam logic [4:0] ST_TGT_VEL_SENT    = 5'd10;
  localparam logic [4:0] ST_TGT_VEL_RECV    = 5'd11;
  localparam logic [4:0] ST_CW_VEL_SENT     = 5'd12;
  localparam logic [4:0] ST_CW_VEL_RECV     = 5'd13;
  localparam logic [4:0] ST_VEL_POLL_SENT   = 5'd14;
  localparam logic [4:0] ST_VEL_RECV        = 5'd15;
  localparam logic [4:0] ST_CUR_POLL_SENT   = 5'd16;
  localparam logic [4:0] ST_CUR_RECV        = 5'd17;
  localparam logic [4:0] ST_POS_POLL_SENT   = 5'd18;
  localparam logic [4:0] ST_IDLE            = 5'd19;
  localparam logic [4:0] ST_FAULT           = 5'd20;
  localparam logic [4:0] ST_FAULT_RST_SENT  = 5'd21;
  localparam logic [4:0] ST_FAULT_RST_RECV  = 5'd22;
  localparam logic [4:0] ST_MAX             = ST_FAULT_RST_RECV;

  // Pending message codes.
  localparam logic [3:0] MSG_IDLE        = 4'd0;
  localparam logic [3:0] MSG_CW_SHUTDOWN = 4'd1;
  localparam logic [3:0] MSG_CW_SWITCH   = 4'd2;
  localparam logic [3:0] MSG_CW_ENABLE   = 4'd3;
  localparam logic [3:0] MSG_SW_READ     = 4'd4;
  localparam logic [3:0] MSG_TGT_VEL     = 4'd5;
  localparam logic [3:0] MSG_CW_AFTER    = 4'd6;
  localparam logic [3:0] MSG_VEL_READ    = 4'd7;
  localparam logic [3:0] MSG_CUR_READ    = 4'd8;
  localparam logic [3:0] MSG_POS_READ    = 4'd9;
  localparam logic [3:0] MSG_FAULT_RST   = 4'd10;
  localparam logic [3:0] MSG_MAX         = MSG_FAULT_RST;

  // Masked statusword values.
  localparam logic [15:0] SW_MASK          = 16'h417f;
  localparam logic [15:0] SW_NOT_READY     = 16'h0000;
  localparam logic [15:0] SW_NOT_READY_RMT = 16'h0100;
  localparam logic [15:0] SW_ENABLED_ALT_A = 16'h4123;
  localparam logic [15:0] SW_ENABLED_ALT_B = 16'h4133;
  localparam logic [15:0] SW_DISABLED_VAL  = 16'h0140;
  localparam logic [15:0] SW_READY_VAL     = 16'h0121;
  localparam logic [15:0] SW_SWITCHED_VAL  = 16'h0123;
  localparam logic [15:0] SW_ENABLED_VAL   = 16'h0137;
  localparam logic [15:0] SW_FAULT_VAL     = 16'h0108;
  localparam logic [15:0] SW_QSTOP_VAL     = 16'h0117;
  localparam logic [15:0] SW_REACT_A_VAL   = 16'h010f;
  localparam logic [15:0] SW_REACT_B_VAL   = 16'h011f;

  typedef enum logic [2:0] {
    SWC_RESTART     = 3'd0,
    SWC_DISABLED    = 3'd1,
    SWC_READY       = 3'd2,
    SWC_SWITCHED_ON = 3'd3,
    SWC_ENABLED     = 3'd4,
    SWC_FAULT       = 3'd5,
    SWC_HOLD        = 3'd6,
    SWC_UNKNOWN     = 3'd7
  } sw_class_t;

  // One classified event, as it travels from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       known;
    logic [1:0] slot;
    logic [2:0] kind;
    sw_class_t  sw_class;
    logic       force_bad;
    logic [4:0] forced_state;
    logic [3:0] forced_message;
  } evt_t;

  function automatic sw_class_t classify_status(input logic [15:0] sw);
    logic [15:0] masked;
    sw_class_t   cls;
    masked = sw & SW_MASK;
    case (masked)
      SW_NOT_READY, SW_NOT_READY_RMT, SW_ENABLED_ALT_A, SW_ENABLED_ALT_B: cls = SWC_RESTART;
      SW_DISABLED_VAL: cls = SWC_DISABLED;
      SW_READY_VAL:    cls = SWC_READY;
      SW_SWITCHED_VAL: cls = SWC_SWITCHED_ON;
      SW_ENABLED_VAL:  cls = SWC_ENABLED;
      SW_FAULT_VAL:    cls = SWC_FAULT;
      SW_QSTOP_VAL, SW_REACT_A_VAL, SW_REACT_B_VAL: cls = SWC_HOLD;
      default:         cls = SWC_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic logic is_waiting(input logic [4:0] s);
    return (s == ST_STATUS_SENT) || (s == ST_SHUTDOWN_SENT) ||
           (s == ST_SWITCH_ON_SENT) || (s == ST_ENABLE_SENT) ||
           (s == ST_TGT_VEL_SENT) || (s == ST_CW_VEL_SENT) ||
           (s == ST_VEL_POLL_SENT) || (s == ST_CUR_POLL_SENT) ||
           (s == ST_POS_POLL_SENT) || (s == ST_FAULT_RST_SENT);
  endfunction

endpackage

>>> rtl/canopen_drive_state_sequencer_core.sv
// Input transfers are written into the queue; a pop then updates the table and the result register.
// Throughput: one item per cycle unless output stalls; a pop reads and updates the slot table.
// The two-entry queue and the result register let the input and output stall independently.
// Reset clears every slot to state 0 with no pending message, and the node ids to 2, 4, 8.
// The slot table is in flip-flops, so no clearing pass follows reset.
module canopen_drive_state_sequencer_core #(
  parameter int NODE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [10:0] can_id,
  input  logic [2:0]  object_kind,
  input  logic [15:0] status_word,
  input  logic [1:0]  node_select,
  input  logic [4:0]  forced_state,
  input  logic [3:0]  forced_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  node_index,
  output logic        node_known,
  output logic [4:0]  drive_state,
  output logic [3:0]  next_message,
  output logic        awaiting_reply,
  output logic        event_error
);
  import cdss_pkg::*;

  evt_t front_evt;
  evt_t head;
  logic head_valid;
  logic pop;

  cdss_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .can_id         (can_id),
    .object_kind    (object_kind),
    .status_word    (status_word),
    .node_select    (node_select),
    .forced_state   (forced_state),
    .forced_message (forced_message),
    .evt            (front_evt)
  );

  cdss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_evt),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  cdss_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .node_index     (node_index),
    .node_known     (node_known),
    .drive_state    (drive_state),
    .next_message   (next_message),
    .awaiting_reply (awaiting_reply),
    .event_error    (event_error)
  );

endmodule

>>> rtl/cdss_front.sv
// Front end: node id registers, slot resolution and event classification.
module cdss_front #(
  parameter int NODE_COUNT = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic [1:0]          op,
  input  logic [10:0]         can_id,
  input  logic [2:0]          object_kind,
  input  logic [15:0]         status_word,
  input  logic [1:0]          node_select,
  input  logic [4:0]          forced_state,
  input  logic [3:0]          forced_message,
  output cdss_pkg::evt_t      evt
);
  import cdss_pkg::*;

  logic [6:0] node_id [SLOT_COUNT];
  logic       sent_found;
  logic [1:0] sent_slot;
  logic       recv_found;
  logic [1:0] recv_slot;
  op_t        op_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id[0] <= NODE_ID_A_RESET;
      node_id[1] <= NODE_ID_B_RESET;
      node_id[2] <= NODE_ID_C_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_ID_A: node_id[0] <= cfg_data;
        CFG_NODE_ID_B: node_id[1] <= cfg_data;
        CFG_NODE_ID_C: node_id[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Both bases have their low seven bits clear, so a match is a prefix
  // compare on the upper bits and an equality on the node id bits.
  always_comb begin
    sent_found = 1'b0;
    sent_slot  = 2'd0;
    recv_found = 1'b0;
    recv_slot  = 2'd0;
    for (int k = NODE_COUNT - 1; k >= 0; k--) begin
      if (can_id[10:7] == SENT_BASE[10:7] && can_id[6:0] == node_id[k]) begin
        sent_found = 1'b1;
        sent_slot  = 2'(k);
      end
      if (can_id[10:7] == RECV_BASE[10:7] && can_id[6:0] == node_id[k]) begin
        recv_found = 1'b1;
        recv_slot  = 2'(k);
      end
    end
  end

  always_comb begin
    op_code            = op_t'(op);
    evt.op             = op_code;
    evt.kind           = object_kind;
    evt.sw_class       = classify_status(status_word);
    evt.force_bad      = (forced_state > ST_MAX) || (forced_message > MSG_MAX);
    evt.forced_state   = forced_state;
    evt.forced_message = forced_message;
    case (op_code)
      OP_SENT: begin
        evt.known = sent_found;
        evt.slot  = sent_slot;
      end
      OP_RECV: begin
        evt.known = recv_found;
        evt.slot  = recv_slot;
      end
      default: begin
        evt.known = (node_select < 2'(NODE_COUNT));
        evt.slot  = evt.known ? node_select : 2'd0;
      end
    endcase
  end

endmodule

>>> rtl/cdss_queue.sv
// Two-entry event queue between the front end and the back end.
`include "canopen_drive_state_sequencer_core_defines.svh"

module cdss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  cdss_pkg::evt_t push_data,
  output logic           head_valid,
  input  logic           pop,
  output cdss_pkg::evt_t head
);
  import cdss_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CDSS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `CDSS_ASSERT_NOW(a_no_pop_when_empty, pop, count != '0)
  `CDSS_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/cdss_back.sv
// Back end: per-slot state table update and the registered result stage.
`include "canopen_drive_state_sequencer_core_defines.svh"

module cdss_back #(
  parameter int NODE_COUNT = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  cdss_pkg::evt_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     node_index,
  output logic           node_known,
  output logic [4:0]     drive_state,
  output logic [3:0]     next_message,
  output logic           awaiting_reply,
  output logic           event_error
);
  import cdss_pkg::*;

  localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [4:0]        state_tab [NODE_COUNT];
  logic [3:0]        msg_tab   [NODE_COUNT];
  logic [SLOT_W-1:0] idx;
  logic [4:0]        cur_s;
  logic [3:0]        cur_m;
  logic [4:0]        new_s;
  logic [3:0]        new_m;
  logic              err;

  assign pop   = head_valid && (!out_valid || out_ready);
  assign idx   = head.slot[SLOT_W-1:0];
  assign cur_s = state_tab[idx];
  assign cur_m = msg_tab[idx];

  always_comb begin
    new_s = cur_s;
    new_m = cur_m;
    err   = 1'b0;
    case (head.op)
      OP_SENT: begin
        // Any sent frame for a known node consumes the pending message, even a rejected one.
        new_m = MSG_IDLE;
        err   = 1'b1;
        case (head.kind)
          OBJ_CONTROLWORD: begin
            case (cur_s)
              ST_SW_ON_DISABLED: begin new_s = ST_SHUTDOWN_SENT;  err = 1'b0; end
              ST_READY_SW_ON:    begin new_s = ST_SWITCH_ON_SENT; err = 1'b0; end
              ST_SWITCHED_ON:    begin new_s = ST_ENABLE_SENT;    err = 1'b0; end
              ST_TGT_VEL_RECV:   begin new_s = ST_CW_VEL_SENT;    err = 1'b0; end
              ST_FAULT:          begin new_s = ST_FAULT_RST_SENT; err = 1'b0; end
              default: ;
            endcase
          end
          OBJ_STATUSWORD: begin
            if (cur_s == ST_GET_STATUS) begin new_s = ST_STATUS_SENT; err = 1'b0; end
          end
          OBJ_TARGET_VEL: begin
            if (cur_s == ST_OP_ENABLED) begin new_s = ST_TGT_VEL_SENT; err = 1'b0; end
          end
          OBJ_VELOCITY: begin
            if (cur_s == ST_CW_VEL_RECV) begin new_s = ST_VEL_POLL_SENT; err = 1'b0; end
          end
          OBJ_CURRENT: begin
            if (cur_s == ST_VEL_RECV) begin new_s = ST_CUR_POLL_SENT; err = 1'b0; end
          end
          OBJ_POSITION: begin
            if (cur_s == ST_CUR_RECV) begin new_s = ST_POS_POLL_SENT; err = 1'b0; end
          end
          default: ;
        endcase
      end
      OP_RECV: begin
        err = 1'b1;
        case (head.kind)
          OBJ_CONTROLWORD: begin
            if (cur_s == ST_SHUTDOWN_SENT || cur_s == ST_SWITCH_ON_SENT ||
                cur_s == ST_ENABLE_SENT || cur_s == ST_FAULT_RST_SENT) begin
              new_s = ST_GET_STATUS;
              new_m = MSG_SW_READ;
              err   = 1'b0;
            end else if (cur_s == ST_CW_VEL_SENT) begin
              new_s = ST_CW_VEL_RECV;
              new_m = MSG_VEL_READ;
              err   = 1'b0;
            end
          end
          OBJ_STATUSWORD: begin
            if (cur_s == ST_STATUS_SENT) begin
              err = 1'b0;
              case (head.sw_class)
                SWC_RESTART:     begin new_s = ST_GET_STATUS;     new_m = MSG_SW_READ;     end
                SWC_DISABLED:    begin new_s = ST_SW_ON_DISABLED; new_m = MSG_CW_SHUTDOWN; end
                SWC_READY:       begin new_s = ST_READY_SW_ON;    new_m = MSG_CW_SWITCH;   end
                SWC_SWITCHED_ON: begin new_s = ST_SWITCHED_ON;    new_m = MSG_CW_ENABLE;   end
                SWC_ENABLED:     begin new_s = ST_OP_ENABLED;     new_m = MSG_TGT_VEL;     end
                SWC_FAULT:       begin new_s = ST_FAULT;          new_m = MSG_FAULT_RST;   end
                SWC_HOLD:        ;
                default:         err = 1'b1;
              endcase
            end
          end
          OBJ_TARGET_VEL: begin
            if (cur_s == ST_TGT_VEL_SENT) begin
              new_s = ST_TGT_VEL_RECV; new_m = MSG_CW_AFTER; err = 1'b0;
            end
          end
          OBJ_VELOCITY: begin
            if (cur_s == ST_VEL_POLL_SENT) begin
              new_s = ST_VEL_RECV; new_m = MSG_CUR_READ; err = 1'b0;
            end
          end
          OBJ_CURRENT: begin
            if (cur_s == ST_CUR_POLL_SENT) begin
              new_s = ST_CUR_RECV; new_m = MSG_POS_READ; err = 1'b0;
            end
          end
          OBJ_POSITION: begin
            if (cur_s == ST_POS_POLL_SENT) begin
              new_s = ST_GET_STATUS; new_m = MSG_SW_READ; err = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_FORCE: begin
        if (head.force_bad) begin
          err = 1'b1;
        end else begin
          new_s = head.forced_state;
          new_m = head.forced_message;
        end
      end
      default: ;
    endcase
    if (!head.known) begin
      err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NODE_COUNT; k++) begin
        state_tab[k] <= ST_BEFORE_START;
        msg_tab[k]   <= MSG_IDLE;
      end
    end else if (pop && head.known) begin
      state_tab[idx] <= new_s;
      msg_tab[idx]   <= new_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      node_index     <= head.known ? head.slot : 2'd0;
      node_known     <= head.known;
      drive_state    <= head.known ? new_s : ST_BEFORE_START;
      next_message   <= head.known ? new_m : MSG_IDLE;
      awaiting_reply <= head.known && is_waiting(new_s);
      event_error    <= err;
    end
  end

  `CDSS_ASSERT_NOW(a_unknown_is_zero, out_valid && !node_known,
                   event_error && drive_state == ST_BEFORE_START && next_message == MSG_IDLE)
  `CDSS_ASSERT_NOW(a_wait_flag_match, out_valid, awaiting_reply == is_waiting(drive_state))
  `CDSS_ASSERT_NEXT(a_pop_loads_result, pop, out_valid)

endmodule
